// File: design/dwp_pkg.sv
// Shared types, widths and codes for the dual wheel PI drive block.
// No dependencies; every other design file imports this package.
package dwp_pkg;

  // Field widths
  localparam int POS_W     = 16;             // encoder setpoints and counts
  localparam int GAIN_W    = 8;
  localparam int DIV_W     = 8;
  localparam int DUTY_W    = 8;
  localparam int ERR_W     = POS_W + 1;      // setpoint - count
  localparam int PROD_W    = ERR_W + GAIN_W; // error * gain
  localparam int SUM_W     = POS_W + 2;      // integral + error
  localparam int QUOT_W    = POS_W + 1;      // signed integral quotient
  localparam int DRIVE_W   = PROD_W + 1;     // proportional + integral term
  localparam int DIV_STEPS = POS_W;          // one quotient bit per step
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int DRIVE_LIMIT = 255;

  // APB register file
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_MAX     = 3'd1,
    REG_I_MIN     = 3'd2,
    REG_I_DIVISOR = 3'd3,
    REG_I_ENABLE  = 3'd4
  } reg_idx_t;

  // Reset values
  localparam logic [GAIN_W-1:0]       RST_P_GAIN    = GAIN_W'(1);
  localparam logic signed [POS_W-1:0] RST_I_MAX     = POS_W'(1024);
  localparam logic signed [POS_W-1:0] RST_I_MIN     = -POS_W'(1024);
  localparam logic [DIV_W-1:0]        RST_I_DIVISOR = DIV_W'(16);
  localparam logic                    RST_I_ENABLE  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]       p_gain;
    logic signed [POS_W-1:0] integral_max;
    logic signed [POS_W-1:0] integral_min;
    logic [DIV_W-1:0]        integral_divisor;
    logic                    integral_enable;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_CLAMP,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

// File: design/dwp_if.sv
// Valid/ready channel interfaces for the tick word and the duty word.
// Depends on dwp_pkg for field widths.
interface dwp_in_if;
  import dwp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] setpoint_left;
  logic signed [POS_W-1:0] setpoint_right;
  logic signed [POS_W-1:0] count_left;
  logic signed [POS_W-1:0] count_right;

  modport source (
    output valid, setpoint_left, setpoint_right, count_left, count_right,
    input  ready
  );
  modport sink (
    input  valid, setpoint_left, setpoint_right, count_left, count_right,
    output ready
  );
endinterface

interface dwp_out_if;
  import dwp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_forward_duty;
  logic [DUTY_W-1:0] left_reverse_duty;
  logic [DUTY_W-1:0] right_forward_duty;
  logic [DUTY_W-1:0] right_reverse_duty;

  modport source (
    output valid, left_forward_duty, left_reverse_duty,
           right_forward_duty, right_reverse_duty,
    input  ready
  );
  modport sink (
    input  valid, left_forward_duty, left_reverse_duty,
           right_forward_duty, right_reverse_duty,
    output ready
  );
endinterface

// File: design/dwp_cfg.sv
// APB register file holding gain, integral clamps, divisor and mode.
// Depends on dwp_pkg.
module dwp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwp_pkg::PADDR_W-1:0]   paddr,
  input  logic [dwp_pkg::PDATA_W-1:0]   pwdata,
  output logic [dwp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dwp_pkg::cfg_t                 cfg
);
  import dwp_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // Decode the write; addresses past the last register drop the word
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_P_GAIN:    cfg_nxt.p_gain           = pwdata[GAIN_W-1:0];
        REG_I_MAX:     cfg_nxt.integral_max     = $signed(pwdata[POS_W-1:0]);
        REG_I_MIN:     cfg_nxt.integral_min     = $signed(pwdata[POS_W-1:0]);
        REG_I_DIVISOR: cfg_nxt.integral_divisor = pwdata[DIV_W-1:0];
        REG_I_ENABLE:  cfg_nxt.integral_enable  = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain           <= RST_P_GAIN;
      cfg_r.integral_max     <= RST_I_MAX;
      cfg_r.integral_min     <= RST_I_MIN;
      cfg_r.integral_divisor <= RST_I_DIVISOR;
      cfg_r.integral_enable  <= RST_I_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back; signed clamps come back sign-extended
  always_comb begin
    unique case (idx)
      REG_P_GAIN:    prdata = PDATA_W'(cfg_r.p_gain);
      REG_I_MAX:     prdata = PDATA_W'($signed(cfg_r.integral_max));
      REG_I_MIN:     prdata = PDATA_W'($signed(cfg_r.integral_min));
      REG_I_DIVISOR: prdata = PDATA_W'(cfg_r.integral_divisor);
      REG_I_ENABLE:  prdata = PDATA_W'(cfg_r.integral_enable);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: design/dwp_div.sv
// Restoring divider: unsigned integral magnitude by the 8-bit divisor,
// one quotient bit per cycle. Depends on dwp_pkg.
module dwp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dwp_pkg::div_req_t req,
  output dwp_pkg::div_rsp_t rsp
);
  import dwp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[POS_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = ~diff[DIV_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      // a zero divisor divides by one
      dsr_nxt  = (req.divisor == '0) ? DIV_W'(1) : req.divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[POS_W-2:0], fits};
      rem_nxt  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: design/dwp_ctrl.sv
// Sequencer and per-wheel datapath: error, gain product, integral clamp,
// divider hand-off, saturation and the output word register. Depends on dwp_pkg.
module dwp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  dwp_pkg::cfg_t     cfg,
  dwp_in_if.sink            in_chan,
  dwp_out_if.source         out_chan,
  output dwp_pkg::div_req_t div_req,
  input  dwp_pkg::div_rsp_t div_rsp
);
  import dwp_pkg::*;

  localparam logic signed [DRIVE_W-1:0] DRV_POS = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] DRV_NEG = -DRV_POS;

  state_t state_r, state_nxt;
  logic   wheel_r, wheel_nxt;       // 0 = left, 1 = right
  logic   out_valid_r, out_valid_nxt;

  logic signed [POS_W-1:0]   integ_lf_r, integ_lf_nxt;
  logic signed [POS_W-1:0]   integ_rt_r, integ_rt_nxt;

  logic signed [POS_W-1:0]   sp_lf_r, sp_lf_nxt, sp_rt_r, sp_rt_nxt;
  logic signed [POS_W-1:0]   cnt_lf_r, cnt_lf_nxt, cnt_rt_r, cnt_rt_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      qneg_r, qneg_nxt;
  logic signed [QUOT_W-1:0]  quot_r, quot_nxt;
  logic [DUTY_W-1:0]         lf_fwd_r, lf_fwd_nxt, lf_rev_r, lf_rev_nxt;
  logic [DUTY_W-1:0]         rt_fwd_r, rt_fwd_nxt, rt_rev_r, rt_rev_nxt;
  logic [DUTY_W-1:0]         o_lf_fwd_r, o_lf_fwd_nxt, o_lf_rev_r, o_lf_rev_nxt;
  logic [DUTY_W-1:0]         o_rt_fwd_r, o_rt_fwd_nxt, o_rt_rev_r, o_rt_rev_nxt;

  logic signed [POS_W-1:0]   sp_sel, cnt_sel, integ_sel;
  logic signed [SUM_W-1:0]   clamp_hi, clamp_lo;
  logic signed [POS_W-1:0]   clamp;
  logic [POS_W-1:0]          clamp_mag;
  logic signed [QUOT_W-1:0]  quot_mag;
  logic signed [DRIVE_W-1:0] drive, drive_neg;
  logic [DUTY_W-1:0]         duty_fwd, duty_rev;
  logic                      in_fire;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;

  // Pick the operands of the wheel being worked on
  assign sp_sel    = wheel_r ? sp_rt_r    : sp_lf_r;
  assign cnt_sel   = wheel_r ? cnt_rt_r   : cnt_lf_r;
  assign integ_sel = wheel_r ? integ_rt_r : integ_lf_r;

  // Clamp: the upper limit wins over the lower one
  assign clamp_hi = SUM_W'($signed(cfg.integral_max));
  assign clamp_lo = SUM_W'($signed(cfg.integral_min));
  always_comb begin
    priority if (sum_r > clamp_hi) begin
      clamp = cfg.integral_max;
    end else if (sum_r < clamp_lo) begin
      clamp = cfg.integral_min;
    end else begin
      clamp = $signed(sum_r[POS_W-1:0]);
    end
  end
  assign clamp_mag = clamp[POS_W-1] ? (~clamp + 1'b1) : clamp;

  // Quotient truncates toward zero: divide magnitude, restore sign
  assign quot_mag = $signed({1'b0, div_rsp.quotient});

  // Drive and saturation to the duty pair
  assign drive     = DRIVE_W'(prod_r) + DRIVE_W'(quot_r);
  assign drive_neg = -drive;
  always_comb begin
    if (!drive[DRIVE_W-1] && (drive != '0)) begin
      duty_fwd = (drive > DRV_POS) ? DUTY_W'(DRIVE_LIMIT) : drive[DUTY_W-1:0];
      duty_rev = '0;
    end else begin
      duty_fwd = '0;
      duty_rev = (drive < DRV_NEG) ? DUTY_W'(DRIVE_LIMIT) : drive_neg[DUTY_W-1:0];
    end
  end

  // Divider launch
  always_comb begin
    div_req.start    = (state_r == ST_CLAMP) & cfg.integral_enable;
    div_req.dividend = clamp_mag;
    div_req.divisor  = cfg.integral_divisor;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    wheel_nxt     = wheel_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    integ_lf_nxt  = integ_lf_r;
    integ_rt_nxt  = integ_rt_r;
    sp_lf_nxt     = sp_lf_r;
    sp_rt_nxt     = sp_rt_r;
    cnt_lf_nxt    = cnt_lf_r;
    cnt_rt_nxt    = cnt_rt_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    qneg_nxt      = qneg_r;
    quot_nxt      = quot_r;
    lf_fwd_nxt    = lf_fwd_r;
    lf_rev_nxt    = lf_rev_r;
    rt_fwd_nxt    = rt_fwd_r;
    rt_rev_nxt    = rt_rev_r;
    o_lf_fwd_nxt  = o_lf_fwd_r;
    o_lf_rev_nxt  = o_lf_rev_r;
    o_rt_fwd_nxt  = o_rt_fwd_r;
    o_rt_rev_nxt  = o_rt_rev_r;

    unique case (state_r)
      ST_IDLE: begin
        // take the tick word, start with the left wheel
        if (in_fire) begin
          sp_lf_nxt  = in_chan.setpoint_left;
          sp_rt_nxt  = in_chan.setpoint_right;
          cnt_lf_nxt = in_chan.count_left;
          cnt_rt_nxt = in_chan.count_right;
          wheel_nxt  = 1'b0;
          state_nxt  = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = ERR_W'(sp_sel) - ERR_W'(cnt_sel);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(err_r) * $signed({1'b0, cfg.p_gain});
        sum_nxt   = SUM_W'(integ_sel) + SUM_W'(err_r);
        state_nxt = ST_MUL == state_r ? ST_CLAMP : ST_MUL;
      end
      ST_CLAMP: begin
        if (cfg.integral_enable) begin
          if (wheel_r) begin
            integ_rt_nxt = clamp;
          end else begin
            integ_lf_nxt = clamp;
          end
          qneg_nxt  = clamp[POS_W-1];
          state_nxt = ST_DIV;
        end else begin
          quot_nxt  = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          quot_nxt  = qneg_r ? -quot_mag : quot_mag;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (wheel_r) begin
          rt_fwd_nxt = duty_fwd;
          rt_rev_nxt = duty_rev;
          state_nxt  = ST_OUT;
        end else begin
          lf_fwd_nxt = duty_fwd;
          lf_rev_nxt = duty_rev;
          wheel_nxt  = 1'b1;
          state_nxt  = ST_ERR;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          o_lf_fwd_nxt  = lf_fwd_r;
          o_lf_rev_nxt  = lf_rev_r;
          o_rt_fwd_nxt  = rt_fwd_r;
          o_rt_rev_nxt  = rt_rev_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wheel_r     <= 1'b0;
      out_valid_r <= 1'b0;
      integ_lf_r  <= '0;
      integ_rt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
      integ_lf_r  <= integ_lf_nxt;
      integ_rt_r  <= integ_rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_lf_r    <= sp_lf_nxt;
    sp_rt_r    <= sp_rt_nxt;
    cnt_lf_r   <= cnt_lf_nxt;
    cnt_rt_r   <= cnt_rt_nxt;
    err_r      <= err_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    qneg_r     <= qneg_nxt;
    quot_r     <= quot_nxt;
    lf_fwd_r   <= lf_fwd_nxt;
    lf_rev_r   <= lf_rev_nxt;
    rt_fwd_r   <= rt_fwd_nxt;
    rt_rev_r   <= rt_rev_nxt;
    o_lf_fwd_r <= o_lf_fwd_nxt;
    o_lf_rev_r <= o_lf_rev_nxt;
    o_rt_fwd_r <= o_rt_fwd_nxt;
    o_rt_rev_r <= o_rt_rev_nxt;
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.left_forward_duty  = o_lf_fwd_r;
  assign out_chan.left_reverse_duty  = o_lf_rev_r;
  assign out_chan.right_forward_duty = o_rt_fwd_r;
  assign out_chan.right_reverse_duty = o_rt_rev_r;

endmodule

// File: design/dual_wheel_pi_pwm_drive_core.sv
// Top level of the dual wheel PI drive: register file, sequencer, divider.
// Depends on dwp_pkg, dwp_if, dwp_cfg, dwp_div and dwp_ctrl.
//
// Usage:
//   in_chan  carries one control tick word: left/right setpoints and encoder
//            counts. out_chan carries the four PWM compare values of that tick.
//   APB port (psel .. pready) holds gain, integral clamps, divisor and mode;
//            write it only while the block is idle.
// Timing:
//   One tick word is worked at a time, left wheel then right wheel. Each wheel
//   runs through the single shared restoring divider (16 steps) when integral
//   mode is on; with it off the divider is skipped. The next tick word is taken
//   only once the duty word of the last one is in the output register.
// Reset (rst_n low, synchronous) restores the register defaults, clears both
// integrals and empties the output register. A stalled receiver keeps the duty
// word held; the next tick is still taken and worked, and its result waits
// in the sequencer until the output register frees up.
module dual_wheel_pi_pwm_drive_core (
  input  logic                        clk,
  input  logic                        rst_n,
  dwp_in_if.sink                      in_chan,
  dwp_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dwp_pkg::PADDR_W-1:0] paddr,
  input  logic [dwp_pkg::PDATA_W-1:0] pwdata,
  output logic [dwp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import dwp_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  dwp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dwp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dwp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

endmodule

// File: design/dwp_chk.sv
// Port-level checks for the dual wheel PI drive, bound to the top level.
// Depends on dwp_pkg for the duty width.
module dwp_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dwp_pkg::DUTY_W-1:0] lf_fwd,
  input logic [dwp_pkg::DUTY_W-1:0] lf_rev,
  input logic [dwp_pkg::DUTY_W-1:0] rt_fwd,
  input logic [dwp_pkg::DUTY_W-1:0] rt_rev
);
  import dwp_pkg::*;

  // Reset empties the output and leaves the block ready for a tick
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("output not empty or input not ready after reset");

  // One tick word at a time: taking a word drops ready next cycle
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second tick taken while one is in work");

  // A wheel never drives forward and reverse together
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((lf_fwd == '0 || lf_rev == '0) && (rt_fwd == '0 || rt_rev == '0)))
    else $error("forward and reverse duty both nonzero");

  // A stalled duty word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(lf_fwd) && $stable(lf_rev) && $stable(rt_fwd) && $stable(rt_rev)))
    else $error("stalled duty word changed");

endmodule

bind dual_wheel_pi_pwm_drive_core dwp_chk u_dwp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .lf_fwd    (out_chan.left_forward_duty),
  .lf_rev    (out_chan.left_reverse_duty),
  .rt_fwd    (out_chan.right_forward_duty),
  .rt_rev    (out_chan.right_reverse_duty)
);

// File: tb/dual_wheel_pi_pwm_drive_core_test.sv
// Testbench for dual_wheel_pi_pwm_drive_core: a directed table of ticks and register
// writes, then random phases, checked against typed duty values or a PI drive predictor.
// Depends on dwp_pkg and the dwp_in_if / dwp_out_if channel interfaces.
module dual_wheel_pi_pwm_drive_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dwp_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] sp_left;
    logic signed [POS_W-1:0] sp_right;
    logic signed [POS_W-1:0] cnt_left;
    logic signed [POS_W-1:0] cnt_right;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd_left;
    logic [DUTY_W-1:0] rev_left;
    logic [DUTY_W-1:0] fwd_right;
    logic [DUTY_W-1:0] rev_right;
  } duty_t;

  typedef enum {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    reg_idx_t  idx;
    int        value;
    int        sp_l, sp_r, cnt_l, cnt_r;
    bit        typed;
    int        f_l, r_l, f_r, r_r;
  } plan_row_t;

  localparam int PLAN_LEN   = 32;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 120;
  localparam int CORNER [5] = '{-32768, -1, 0, 1, 32767};

  logic                 clk;
  logic                 rst_n   = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  dwp_in_if  tick_ch ();
  dwp_out_if duty_ch ();

  dual_wheel_pi_pwm_drive_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (tick_ch),
    .out_chan (duty_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor copy of the registers and the two integrals
  logic [GAIN_W-1:0]       kp        = RST_P_GAIN;
  logic signed [POS_W-1:0] clamp_hi  = RST_I_MAX;
  logic signed [POS_W-1:0] clamp_lo  = RST_I_MIN;
  logic [DIV_W-1:0]        idiv      = RST_I_DIVISOR;
  logic                    pi_on     = RST_I_ENABLE;
  logic signed [POS_W-1:0] integ_left  = '0;
  logic signed [POS_W-1:0] integ_right = '0;

  duty_t     pending_duty [$];
  plan_row_t plan [PLAN_LEN];
  bit        tick_held = 1'b0;
  int        tick_gap  = 0;
  bit        no_idle   = 1'b0;
  int        mismatches     = 0;
  int        ticks_sent     = 0;
  int        words_checked  = 0;
  int        reg_writes     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // One wheel: error, P term, clamped integral, saturated drive split
  function automatic void wheel_drive(input logic signed [POS_W-1:0] sp,
                                      input logic signed [POS_W-1:0] cnt,
                                      inout logic signed [POS_W-1:0] integ,
                                      output logic [DUTY_W-1:0] fwd,
                                      output logic [DUTY_W-1:0] rev);
    longint err, drv, acc, dv;
    err = longint'(sp) - longint'(cnt);
    drv = err * longint'(kp);
    if (pi_on) begin
      acc = longint'(integ) + err;
      // max is tested first, so min > max still yields a defined value
      if (acc > longint'(clamp_hi)) begin
        acc = longint'(clamp_hi);
      end else if (acc < longint'(clamp_lo)) begin
        acc = longint'(clamp_lo);
      end
      integ = acc[POS_W-1:0];
      dv = (idiv == '0) ? 64'sd1 : longint'(idiv);
      drv = drv + acc / dv;
    end
    if (drv > 0) begin
      fwd = (drv > DRIVE_LIMIT) ? DUTY_W'(DRIVE_LIMIT) : DUTY_W'(drv);
      rev = '0;
    end else begin
      fwd = '0;
      rev = (drv < -DRIVE_LIMIT) ? DUTY_W'(DRIVE_LIMIT) : DUTY_W'(-drv);
    end
  endfunction

  function automatic duty_t pi_tick(input tick_t t);
    duty_t d;
    wheel_drive(t.sp_left, t.cnt_left, integ_left, d.fwd_left, d.rev_left);
    wheel_drive(t.sp_right, t.cnt_right, integ_right, d.fwd_right, d.rev_right);
    return d;
  endfunction

  // Mostly small errors around a random count, some full range, corners, equal
  function automatic void rand_wheel(output logic signed [POS_W-1:0] sp,
                                     output logic signed [POS_W-1:0] cnt);
    int mode, c, s;
    mode = $urandom_range(0, 9);
    c = $signed(16'($urandom));
    if (mode <= 5) begin
      s = c + $urandom_range(0, 160) - 80;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end else if (mode <= 7) begin
      s = $signed(16'($urandom));
    end else if (mode == 8) begin
      c = CORNER[$urandom_range(0, 4)];
      s = CORNER[$urandom_range(0, 4)];
    end else begin
      s = c;
    end
    sp  = 16'(s);
    cnt = 16'(c);
  endfunction

  task automatic report(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Register write plus readback, only once every duty word is home
  task automatic reg_write(input reg_idx_t idx, input int value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] got;
    if (tick_held) begin
      tick_ch.valid <= 1'b0;
      tick_held = 1'b0;
    end
    while (pending_duty.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_P_GAIN:    begin kp = GAIN_W'(value);      mask = 32'hFF;   end
      REG_I_MAX:     begin clamp_hi = POS_W'(value); mask = 32'hFFFF; end
      REG_I_MIN:     begin clamp_lo = POS_W'(value); mask = 32'hFFFF; end
      REG_I_DIVISOR: begin idiv = DIV_W'(value);     mask = 32'hFF;   end
      REG_I_ENABLE:  begin pi_on = value[0];         mask = 32'h1;    end
      default:       mask = '0;
    endcase
    reg_writes++;
    // read it back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((got & mask) !== (PDATA_W'(value) & mask)) begin
      report($sformatf("readback of register %s", idx.name()),
             int'(PDATA_W'(value) & mask), int'(got & mask));
    end
  endtask

  // Drive one tick word, keep valid high when the next one follows at once
  task automatic send_tick(input tick_t t, input bit typed, input duty_t want);
    duty_t guess;
    int g;
    if (!tick_held) begin
      repeat (tick_gap) @(posedge clk);
      tick_ch.valid <= 1'b1;
    end
    tick_ch.setpoint_left  <= t.sp_left;
    tick_ch.setpoint_right <= t.sp_right;
    tick_ch.count_left     <= t.cnt_left;
    tick_ch.count_right    <= t.cnt_right;
    do @(posedge clk); while (!tick_ch.ready);
    guess = pi_tick(t);
    pending_duty.push_back(typed ? want : guess);
    ticks_sent++;
    g = draw_gap();
    if (g == 0) begin
      tick_held = 1'b1;
    end else begin
      tick_ch.valid <= 1'b0;
      tick_held = 1'b0;
      tick_gap = g;
    end
  endtask

  task automatic pick_setting();
    int r, hi, lo;
    r = $urandom_range(0, 5);
    case (r)
      0:       reg_write(REG_P_GAIN, 0);
      1:       reg_write(REG_P_GAIN, 255);
      2, 3:    reg_write(REG_P_GAIN, $urandom_range(1, 8));
      default: reg_write(REG_P_GAIN, $urandom_range(0, 255));
    endcase
    r = $urandom_range(0, 4);
    case (r)
      0: begin hi = 32767; lo = -32768; end
      1: begin hi = $urandom_range(0, 2000); lo = -int'($urandom_range(0, 2000)); end
      2: begin hi = -int'($urandom_range(0, 500)); lo = $urandom_range(0, 500); end
      default: begin hi = $signed(16'($urandom)); lo = $signed(16'($urandom)); end
    endcase
    reg_write(REG_I_MAX, hi);
    reg_write(REG_I_MIN, lo);
    r = $urandom_range(0, 5);
    case (r)
      0:       reg_write(REG_I_DIVISOR, 0);
      1:       reg_write(REG_I_DIVISOR, 1);
      2:       reg_write(REG_I_DIVISOR, 255);
      default: reg_write(REG_I_DIVISOR, $urandom_range(1, 255));
    endcase
    reg_write(REG_I_ENABLE, ($urandom_range(0, 3) != 0) ? 1 : 0);
  endtask

  // Duty word receiver with random stalls
  initial begin
    int g;
    duty_ch.ready = 1'b0;
    forever begin
      g = draw_gap();
      if (g > 0) begin
        duty_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      duty_ch.ready <= 1'b1;
      do @(posedge clk); while (duty_ch.valid !== 1'b1);
    end
  end

  // Compare each accepted duty word with the oldest expectation
  always @(posedge clk) begin : duty_check
    duty_t got;
    duty_t want;
    if (rst_n && duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1) begin
      got = '{duty_ch.left_forward_duty, duty_ch.left_reverse_duty,
              duty_ch.right_forward_duty, duty_ch.right_reverse_duty};
      words_checked++;
      if (pending_duty.size() == 0) begin
        $display("%0t: unexpected duty word, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_duty.pop_front();
        if (got.fwd_left !== want.fwd_left)
          report("left forward duty", want.fwd_left, got.fwd_left);
        if (got.rev_left !== want.rev_left)
          report("left reverse duty", want.rev_left, got.rev_left);
        if (got.fwd_right !== want.fwd_right)
          report("right forward duty", want.fwd_right, got.fwd_right);
        if (got.rev_right !== want.rev_right)
          report("right reverse duty", want.rev_right, got.rev_right);
      end
    end
  end

  initial begin
    tick_t t;
    duty_t w;
    int    directed;
    tick_ch.valid          = 1'b0;
    tick_ch.setpoint_left  = '0;
    tick_ch.setpoint_right = '0;
    tick_ch.count_left     = '0;
    tick_ch.count_right    = '0;

    // kind, reg, value, sp_l, sp_r, cnt_l, cnt_r, typed, fwd_l, rev_l, fwd_r, rev_r
    plan = '{
      // reset defaults: gain 1, PI on, clamps +-1024, divisor 16
      '{ROW_TICK, REG_P_GAIN, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 32767, -32768, -32768, 32767, 1, 255, 0, 0, 255},
      '{ROW_TICK, REG_P_GAIN, 0, -32768, 32767, 32767, -32768, 1, 0, 255, 255, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 40, -40, 0, 0, 0, 0, 0, 0, 0},
      // proportional only
      '{ROW_REG, REG_I_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 100, 0, 0, 100, 1, 100, 0, 0, 100},
      '{ROW_TICK, REG_P_GAIN, 0, 777, -5, 777, -5, 1, 0, 0, 0, 0},
      '{ROW_REG, REG_P_GAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 32767, -32768, -32768, 32767, 1, 0, 0, 0, 0},
      '{ROW_REG, REG_P_GAIN, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 1, 0, 0, 1, 1, 255, 0, 0, 255},
      '{ROW_TICK, REG_P_GAIN, 0, -1, 0, 0, 0, 1, 0, 255, 0, 0},
      // integral only, divisor zero acts as one, widest clamps
      '{ROW_REG, REG_I_ENABLE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_P_GAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_DIVISOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_MAX, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_MIN, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 3, 0, 0, 3, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0},
      // crossed clamps: min above max
      '{ROW_REG, REG_I_MAX, -100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_MIN, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 50, -50, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 300, -300, 0, 0, 0, 0, 0, 0, 0},
      // largest divisor
      '{ROW_REG, REG_I_DIVISOR, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_MAX, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_I_MIN, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, REG_P_GAIN, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, 32767, -32768, -32768, 32767, 0, 0, 0, 0, 0},
      '{ROW_TICK, REG_P_GAIN, 0, -7, 9, 9, -7, 0, 0, 0, 0, 0}
    };

    // hold reset, then release
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_REG) begin
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        t = '{16'(plan[i].sp_l), 16'(plan[i].sp_r), 16'(plan[i].cnt_l), 16'(plan[i].cnt_r)};
        w = '{8'(plan[i].f_l), 8'(plan[i].r_l), 8'(plan[i].f_r), 8'(plan[i].r_r)};
        send_tick(t, plan[i].typed, w);
      end
    end
    directed = ticks_sent;

    // random phases, each with a fresh register setting
    w = '0;
    for (int p = 0; p < PHASES; p++) begin
      pick_setting();
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
        rand_wheel(t.sp_left, t.cnt_left);
        rand_wheel(t.sp_right, t.cnt_right);
        send_tick(t, 1'b0, w);
      end
    end

    // drop valid, drain, then allow for a stray late word
    if (tick_held) begin
      tick_ch.valid <= 1'b0;
      tick_held = 1'b0;
    end
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d control ticks (%0d from the directed table) and %0d duty words",
             ticks_sent, directed, words_checked);
    $display("across %0d register writes in %0d random settings; %0d mismatches",
             reg_writes, PHASES, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
